[design/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHT_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHT_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

[design/rht_pkg.sv]
package rht_pkg;

    localparam int DEF_HISTORY_DEPTH = 8;

    localparam int SER_W  = 32;
    localparam int TAG_W  = 16;
    localparam int POS_W  = 3;
    localparam int CMD_W  = 2;
    localparam int MAXE_W = 4;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Most entries that one build may list, whatever the table depth.
    localparam logic [4:0] LIST_CAP = 5'd8;

    localparam logic [SER_W-1:0] WINDOW_RESET = 32'h0000_0100;
    localparam logic [SER_W-1:0] SERIAL_RESET = 32'h0000_0001;
    localparam logic [SER_W-1:0] SERIAL_MAX   = 32'hFFFF_FFFF;
    localparam logic [SER_W-1:0] SIGN_FLIP    = 32'h8000_0000;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd2;

    localparam logic [APB_ADDR_W-1:0] ADDR_RETAIN_WINDOW = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_NULL,
        ST_SORT_LOAD,
        ST_SORT_CMP,
        ST_SORT_ROW,
        ST_LIST,
        ST_FLUSH,
        ST_CLEAR
    } rht_state_t;

endpackage

[design/recency_history_table_core.sv]
// Recency history table. The block keeps HISTORY_DEPTH entries, each a 16-bit tag with a
// 32-bit age serial, where a serial of zero marks an empty entry. A command transaction
// on the input channel is one of: insert (the tag and the current serial counter go into
// the entry with the lowest serial, the highest index winning a tie), remove oldest (the
// lowest nonzero serial is cleared), or build (the entries are exchange-sorted by
// descending serial, then listed from the front until an empty entry, a stale entry
// whose serial is below counter minus retain_window as a signed comparison, or the limit
// given by max_entries, capped at eight; trailing serials are then cleared unless the
// listing stopped on an empty entry, and the counter advances by one). Any other command
// code yields a single null result. Insert and remove return one result transaction;
// build returns one per listed entry with last set on the final one, or a single null
// result with listed low when nothing was listed. All work runs through one 32-bit
// magnitude comparator and one read/write port on the entry file, sequenced by a small
// state machine, and in_ready is high only while the block is idle. An insert or remove
// scans every entry, then updates the chosen one. A build sorts the entries, one
// compare-exchange per cycle, then lists entries, closes the listing and clears the
// trailing entries. Results are held in an output register, so a waiting result does
// not stop the next command from being accepted once the block is idle. The only
// configuration register, retain_window, sits at byte address 0 of the APB port and
// resets to 256; it must only be written while the block is idle.
module recency_history_table_core
    import rht_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Command channel.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [TAG_W-1:0]      entry_tag,
    input  logic [MAXE_W-1:0]     max_entries,
    // Result channel.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [POS_W-1:0]      position,
    output logic [TAG_W-1:0]      tag_out,
    output logic [SER_W-1:0]      serial_out,
    output logic                  listed,
    output logic                  last,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // The index counter has one spare bit so that it can hold the depth itself.
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);
    localparam logic [4:0]       LIM_DEPTH =
        (HISTORY_DEPTH > 8) ? LIST_CAP : 5'(HISTORY_DEPTH);

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    rht_state_t          state_reg, state_next;

    logic [SER_W-1:0]    ser_mem_reg [HISTORY_DEPTH];
    logic [TAG_W-1:0]    tag_mem_reg [HISTORY_DEPTH];

    logic [SER_W-1:0]    counter_reg;
    logic [SER_W-1:0]    window_reg;

    // Command context, captured when a transaction is accepted.
    logic [CMD_W-1:0]    cmd_reg;
    logic [TAG_W-1:0]    in_tag_reg;
    logic [CNT_W-1:0]    limit_reg;

    // Sequencer counters: i_reg is the sort row, k_reg scans, compares, lists and clears.
    logic [IDX_W-1:0]    i_reg;
    logic [CNT_W-1:0]    k_reg;

    // Minimum search for insert and remove.
    logic [SER_W-1:0]    best_reg;
    logic [IDX_W-1:0]    at_reg;
    logic [TAG_W-1:0]    at_tag_reg;
    logic                found_reg;

    // The entry that currently occupies the sort row.
    logic [SER_W-1:0]    cur_ser_reg;
    logic [TAG_W-1:0]    cur_tag_reg;

    // Listing.
    logic [SER_W-1:0]    floor_reg;
    logic                clear_reg;
    logic                pend_valid_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic [TAG_W-1:0]    pend_tag_reg;
    logic [SER_W-1:0]    pend_ser_reg;

    // Output register.
    logic                out_valid_reg;
    logic [POS_W-1:0]    position_reg;
    logic [TAG_W-1:0]    tag_out_reg;
    logic [SER_W-1:0]    serial_out_reg;
    logic                listed_reg;
    logic                last_reg;

    // ---------------------------------------------------------------------
    // Combinational control
    // ---------------------------------------------------------------------
    logic                out_free;
    logic [IDX_W-1:0]    rd_idx;
    logic [SER_W-1:0]    rd_ser;
    logic [TAG_W-1:0]    rd_tag;

    logic                wr_en;
    logic                wr_tag_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [SER_W-1:0]    wr_ser;
    logic [TAG_W-1:0]    wr_tag;

    logic [SER_W-1:0]    cmp_a;
    logic [SER_W-1:0]    cmp_b;
    logic                cmp_le;

    logic                emit;
    logic [POS_W-1:0]    emit_pos;
    logic [TAG_W-1:0]    emit_tag;
    logic [SER_W-1:0]    emit_ser;
    logic                emit_listed;
    logic                emit_last;

    logic                take;
    logic                swap;
    logic                list_end;
    logic                list_ok;
    logic                list_take;
    logic [CNT_W-1:0]    i_plus1;
    logic                sort_done;

    logic [4:0]          lim_a;
    logic [4:0]          lim_b;
    logic [4:0]          lim_c;

    logic                cfg_write;

    assign out_free  = !out_valid_reg || out_ready;
    assign rd_ser    = ser_mem_reg[rd_idx];
    assign rd_tag    = tag_mem_reg[rd_idx];

    // The one shared comparator of the block.
    assign cmp_le    = (cmp_a <= cmp_b);

    assign i_plus1   = CNT_W'(i_reg) + ONE_C;
    assign sort_done = (i_plus1 == LAST_C);

    // Listing limit: zero means no limit of its own, then capped at eight and the depth.
    assign lim_a = (max_entries == '0) ? LIST_CAP : {1'b0, max_entries};
    assign lim_b = (lim_a > LIST_CAP) ? LIST_CAP : lim_a;
    assign lim_c = (lim_b > LIM_DEPTH) ? LIM_DEPTH : lim_b;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command)
                        CMD_INSERT: state_next = ST_SCAN;
                        CMD_REMOVE: state_next = ST_SCAN;
                        CMD_BUILD:  state_next = ST_SORT_LOAD;
                        default:    state_next = ST_NULL;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (k_reg == LAST_C)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY, ST_NULL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SORT_LOAD:
            begin
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                if (k_reg == LAST_C)
                begin
                    state_next = ST_SORT_ROW;
                end
            end
            ST_SORT_ROW:
            begin
                state_next = sort_done ? ST_LIST : ST_SORT_CMP;
            end
            ST_LIST:
            begin
                if (!list_ok)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = (clear_reg && (k_reg != DEPTH_C)) ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (k_reg == LAST_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb
    begin
        in_ready    = 1'b0;
        rd_idx      = k_reg[IDX_W-1:0];
        cmp_a       = rd_ser;
        cmp_b       = best_reg;
        wr_en       = 1'b0;
        wr_tag_en   = 1'b0;
        wr_idx      = k_reg[IDX_W-1:0];
        wr_ser      = '0;
        wr_tag      = cur_tag_reg;
        emit        = 1'b0;
        emit_pos    = '0;
        emit_tag    = '0;
        emit_ser    = '0;
        emit_listed = 1'b0;
        emit_last   = 1'b1;
        take        = 1'b0;
        swap        = 1'b0;
        list_end    = 1'b0;
        list_ok     = 1'b0;
        list_take   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                cmp_a = rd_ser;
                cmp_b = best_reg;
                if (cmd_reg == CMD_INSERT)
                begin
                    take = cmp_le;
                end
                else
                begin
                    take = (rd_ser != '0) && cmp_le;
                end
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        wr_en       = 1'b1;
                        wr_tag_en   = 1'b1;
                        wr_idx      = at_reg;
                        wr_ser      = counter_reg;
                        wr_tag      = in_tag_reg;
                        emit_pos    = POS_W'(at_reg);
                        emit_tag    = in_tag_reg;
                        emit_ser    = counter_reg;
                        emit_listed = 1'b1;
                    end
                    else if (found_reg)
                    begin
                        wr_en       = 1'b1;
                        wr_idx      = at_reg;
                        wr_ser      = '0;
                        emit_pos    = POS_W'(at_reg);
                        emit_tag    = at_tag_reg;
                        emit_listed = 1'b1;
                    end
                end
            end
            ST_NULL:
            begin
                emit = out_free;
            end
            ST_SORT_LOAD:
            begin
                rd_idx = '0;
            end
            ST_SORT_CMP:
            begin
                // Swap when the row holder is strictly below the compared entry.
                cmp_a = rd_ser;
                cmp_b = cur_ser_reg;
                swap  = !cmp_le;
                if (swap)
                begin
                    wr_en     = 1'b1;
                    wr_tag_en = 1'b1;
                    wr_ser    = cur_ser_reg;
                    wr_tag    = cur_tag_reg;
                end
            end
            ST_SORT_ROW:
            begin
                // Write the row holder back and load the next row in the same cycle.
                wr_en     = 1'b1;
                wr_tag_en = 1'b1;
                wr_idx    = i_reg;
                wr_ser    = cur_ser_reg;
                wr_tag    = cur_tag_reg;
                rd_idx    = i_plus1[IDX_W-1:0];
            end
            ST_LIST:
            begin
                // Signed compare by flipping both sign bits: not stale when floor <= serial.
                cmp_a    = floor_reg ^ SIGN_FLIP;
                cmp_b    = rd_ser ^ SIGN_FLIP;
                list_end = (k_reg == DEPTH_C) || (k_reg == limit_reg);
                list_ok  = !list_end && (rd_ser != '0) && cmp_le;
                if (list_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            list_take   = 1'b1;
                            emit        = 1'b1;
                            emit_pos    = POS_W'(pend_idx_reg);
                            emit_tag    = pend_tag_reg;
                            emit_ser    = pend_ser_reg;
                            emit_listed = 1'b1;
                            emit_last   = 1'b0;
                        end
                    end
                    else
                    begin
                        list_take = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_valid_reg)
                    begin
                        emit_pos    = POS_W'(pend_idx_reg);
                        emit_tag    = pend_tag_reg;
                        emit_ser    = pend_ser_reg;
                        emit_listed = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                wr_en  = 1'b1;
                wr_ser = '0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Entry file: serials reset to empty, tags to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < HISTORY_DEPTH; e++)
            begin
                ser_mem_reg[e] <= '0;
                tag_mem_reg[e] <= '0;
            end
        end
        else if (wr_en)
        begin
            ser_mem_reg[wr_idx] <= wr_ser;
            if (wr_tag_en)
            begin
                tag_mem_reg[wr_idx] <= wr_tag;
            end
        end
    end

    // Configuration register and serial counter.
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_RETAIN_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RESET;
            counter_reg <= SERIAL_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                window_reg <= pwdata;
            end
            if ((state_reg == ST_FLUSH) && out_free)
            begin
                counter_reg <= counter_reg + SERIAL_RESET;
            end
        end
    end

    assign prdata = (paddr == ADDR_RETAIN_WINDOW) ? window_reg : '0;
    assign pready = 1'b1;

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg          <= '0;
            i_reg          <= '0;
            found_reg      <= 1'b0;
            clear_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
            cmd_reg        <= CMD_INSERT;
            limit_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= command;
                        limit_reg <= CNT_W'(lim_c);
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (take)
                    begin
                        found_reg <= 1'b1;
                    end
                    k_reg <= k_reg + ONE_C;
                end
                ST_SORT_LOAD:
                begin
                    i_reg <= '0;
                    k_reg <= ONE_C;
                end
                ST_SORT_CMP:
                begin
                    k_reg <= k_reg + ONE_C;
                end
                ST_SORT_ROW:
                begin
                    i_reg <= i_plus1[IDX_W-1:0];
                    if (sort_done)
                    begin
                        k_reg          <= '0;
                        clear_reg      <= 1'b1;
                        pend_valid_reg <= 1'b0;
                    end
                    else
                    begin
                        k_reg <= CNT_W'(i_reg) + TWO_C;
                    end
                end
                ST_LIST:
                begin
                    if (list_take)
                    begin
                        pend_valid_reg <= 1'b1;
                        k_reg          <= k_reg + ONE_C;
                    end
                    else if (!list_end && (rd_ser == '0))
                    begin
                        clear_reg <= 1'b0;
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                    end
                end
                ST_CLEAR:
                begin
                    k_reg <= k_reg + ONE_C;
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // Payload registers of the sequencer.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_tag_reg <= entry_tag;
                    best_reg   <= SERIAL_MAX;
                    at_reg     <= '0;
                    at_tag_reg <= '0;
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    best_reg   <= rd_ser;
                    at_reg     <= k_reg[IDX_W-1:0];
                    at_tag_reg <= rd_tag;
                end
            end
            ST_SORT_LOAD:
            begin
                cur_ser_reg <= rd_ser;
                cur_tag_reg <= rd_tag;
                floor_reg   <= counter_reg - window_reg;
            end
            ST_SORT_CMP:
            begin
                if (swap)
                begin
                    cur_ser_reg <= rd_ser;
                    cur_tag_reg <= rd_tag;
                end
            end
            ST_SORT_ROW:
            begin
                cur_ser_reg <= rd_ser;
                cur_tag_reg <= rd_tag;
            end
            ST_LIST:
            begin
                if (list_take)
                begin
                    pend_idx_reg <= k_reg[IDX_W-1:0];
                    pend_tag_reg <= rd_tag;
                    pend_ser_reg <= rd_ser;
                end
            end
            default:
            begin
                best_reg <= best_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            position_reg   <= emit_pos;
            tag_out_reg    <= emit_tag;
            serial_out_reg <= emit_ser;
            listed_reg     <= emit_listed;
            last_reg       <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign position   = position_reg;
    assign tag_out    = tag_out_reg;
    assign serial_out = serial_out_reg;
    assign listed     = listed_reg;
    assign last       = last_reg;

endmodule

[design/rht_checker.sv]
`include "assert_macros.svh"

module rht_checker
    import rht_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [CMD_W-1:0]      command,
    input logic [TAG_W-1:0]      entry_tag,
    input logic [MAXE_W-1:0]     max_entries,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [POS_W-1:0]      position,
    input logic [TAG_W-1:0]      tag_out,
    input logic [SER_W-1:0]      serial_out,
    input logic                  listed,
    input logic                  last,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // A result that is not taken holds still.
    `RHT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(position) && $stable(tag_out) && $stable(serial_out) && $stable(listed) && $stable(last))

    // The port never inserts wait states.
    `RHT_ASSERT_IMP(a_pready_high, clk, rst_n, psel, pready)

    // Once a command is taken the block is busy for at least the following cycle.
    `RHT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // A result that lists nothing is the final one and carries all-zero fields.
    `RHT_ASSERT_IMP(a_null_result, clk, rst_n, out_valid && !listed, last && (position == '0) && (tag_out == '0) && (serial_out == '0))

endmodule

bind recency_history_table_core rht_checker u_rht_checker (.*);
